@@ design/hslw_pkg.sv @@
// ----------------------------------------------------------------------------
// hslw_pkg
// types, widths and the control store of the hex line walker
// ----------------------------------------------------------------------------
package hslw_pkg;

    localparam int TILE_QW    = 5;
    localparam int TILE_SW    = 7;
    localparam int IN_FLD_W   = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USED_W = 2 * TILE_QW + TILE_SW;

    typedef logic [1:0] pc_t;

    localparam pc_t PC_FETCH = 2'd0;
    localparam pc_t PC_SETUP = 2'd1;
    localparam pc_t PC_WALK  = 2'd2;

    typedef enum logic [1:0]
    {
        COND_NONE,
        COND_IN,
        COND_OUT
    } cond_t;

    typedef enum logic
    {
        BR_SEQ,
        BR_LAST
    } br_t;

    typedef struct packed
    {
        cond_t cond;
        logic  take_in;
        logic  setup;
        logic  emit;
        br_t   br;
        pc_t   next_pc;
        pc_t   alt_pc;
    } uop_t;

    function automatic uop_t hslw_rom(input pc_t pc);
        uop_t u;
        u = '{cond: COND_NONE, take_in: 1'b0, setup: 1'b0, emit: 1'b0,
              br: BR_SEQ, next_pc: PC_FETCH, alt_pc: PC_FETCH};
        case (pc)
            PC_FETCH:
            begin
                u.cond    = COND_IN;
                u.take_in = 1'b1;
                u.next_pc = PC_SETUP;
            end
            PC_SETUP:
            begin
                u.setup   = 1'b1;
                u.next_pc = PC_WALK;
            end
            PC_WALK:
            begin
                u.cond    = COND_OUT;
                u.emit    = 1'b1;
                u.br      = BR_LAST;
                u.next_pc = PC_WALK;
                u.alt_pc  = PC_FETCH;
            end
            default:
            begin
                u.next_pc = PC_FETCH;
            end
        endcase
        return u;
    endfunction

endpackage

@@ design/hex_supercover_line_walker.sv @@
// ----------------------------------------------------------------------------
// hex_supercover_line_walker
// four-connected line walk between two axial hex tiles
// ----------------------------------------------------------------------------
// One start/end pair goes in on the slave side; 1 + |dq| + |dr| tiles come
// out on the master side, one per cycle while m_tready is high, the end tile
// marked by m_tlast. Each pair is first taken, then its deltas and the error
// term are set up, then its tiles are walked one by one, paced by a
// three-step control store and the single output register. A new pair is
// taken as soon as the last tile sits in the output register.
module hex_supercover_line_walker #(
    parameter int COORD_BITS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // start_q, start_r, end_q, end_r, zero pad
    input  logic [hslw_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tile_q, tile_r, tile_s, zero pad
    output logic [hslw_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import hslw_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int EW = COORD_BITS + 3;
    localparam int RW = COORD_BITS + 1;

    pc_t  pc_reg, pc_next;
    uop_t uop;
    logic go, out_free, last;

    logic signed [W-1:0]  cq_reg, cr_reg, eq_reg, er_reg;
    logic        [W-1:0]  dq_reg, dr_reg;
    logic                 q_up_reg, r_up_reg;
    logic signed [EW-1:0] err_reg;
    logic        [RW-1:0] rem_reg;

    logic signed [W:0]    diff_q, diff_r;
    logic        [W-1:0]  abs_q, abs_r;
    logic signed [EW-1:0] dq_e, dr_e;

    logic signed [TILE_SW-1:0] q_s, r_s, s_val;

    logic                  m_tvalid_reg;
    logic                  m_tlast_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    assign uop      = hslw_rom(pc_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign last     = (rem_reg == '0);

    always_comb
    begin
        case (uop.cond)
            COND_IN:  go = s_tvalid;
            COND_OUT: go = out_free;
            default:  go = 1'b1;
        endcase
        if (!go)
            pc_next = pc_reg;
        else if (uop.br == BR_LAST && last)
            pc_next = uop.alt_pc;
        else
            pc_next = uop.next_pc;
    end

    assign s_tready = uop.take_in;

    assign diff_q = (W+1)'(eq_reg) - (W+1)'(cq_reg);
    assign diff_r = (W+1)'(er_reg) - (W+1)'(cr_reg);
    assign abs_q  = diff_q[W] ? W'(-diff_q) : W'(diff_q);
    assign abs_r  = diff_r[W] ? W'(-diff_r) : W'(diff_r);
    assign dq_e   = signed'(EW'(dq_reg));
    assign dr_e   = signed'(EW'(dr_reg));

    assign q_s   = TILE_SW'(cq_reg);
    assign r_s   = TILE_SW'(cr_reg);
    assign s_val = -q_s - r_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_FETCH;
        else
            pc_reg <= pc_next;
    end

    always_ff @(posedge clk)
    begin
        if (go && uop.take_in)
        begin
            cq_reg <= s_tdata[W-1:0];
            cr_reg <= s_tdata[IN_FLD_W +: W];
            eq_reg <= s_tdata[2*IN_FLD_W +: W];
            er_reg <= s_tdata[3*IN_FLD_W +: W];
        end
        else if (go && uop.setup)
        begin
            dq_reg   <= abs_q;
            dr_reg   <= abs_r;
            q_up_reg <= eq_reg > cq_reg;
            r_up_reg <= er_reg > cr_reg;
            err_reg  <= signed'(EW'(abs_q)) - signed'(EW'(abs_r));
            rem_reg  <= RW'(abs_q) + RW'(abs_r);
        end
        else if (go && uop.emit)
        begin
            if (err_reg > 0)
            begin
                cq_reg  <= cq_reg + (q_up_reg ? W'(1) : '1);
                err_reg <= err_reg - (dr_e <<< 1);
            end
            else
            begin
                cr_reg  <= cr_reg + (r_up_reg ? W'(1) : '1);
                err_reg <= err_reg + (dq_e <<< 1);
            end
            rem_reg <= rem_reg - RW'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (go && uop.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go && uop.emit)
        begin
            m_tdata_reg <= {(OUT_DATA_W - OUT_USED_W)'(0), s_val,
                            TILE_QW'(cr_reg), TILE_QW'(cq_reg)};
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ design/hslw_checker.sv @@
// ----------------------------------------------------------------------------
// hslw_checker
// port-level checks for the hex line walker
// ----------------------------------------------------------------------------
module hslw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic [hslw_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [hslw_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import hslw_pkg::*;

    logic signed [TILE_SW-1:0] q_x, r_x, s_x;
    logic                      s_ok;

    assign q_x  = TILE_SW'($signed(m_tdata[TILE_QW-1:0]));
    assign r_x  = TILE_SW'($signed(m_tdata[2*TILE_QW-1:TILE_QW]));
    assign s_x  = $signed(m_tdata[OUT_USED_W-1:2*TILE_QW]);
    assign s_ok = (s_x == -q_x - r_x);

    // stalled transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_s_coord: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> s_ok)
        else $error("tile_s is not -q-r");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before setup");

    a_no_take_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("new pair taken before line ended");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
        else $error("output pad bits not zero");

endmodule

bind hex_supercover_line_walker hslw_checker u_hslw_checker (.*);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the axial hex line walker
// ----------------------------------------------------------------------------
// Start/end tile pairs go in on the slave stream. A scoreboard walks each
// line itself and queues the tiles it expects. Every tile that leaves on the
// master stream is compared field by field with the oldest queued tile. The
// stimulus opens with directed corner lines and then sends random pairs in
// three phases with other idle rates on both sides. A long output stall
// is forced once so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 80;

    typedef struct
    {
        logic signed [hslw_pkg::TILE_QW-1:0] q;
        logic signed [hslw_pkg::TILE_QW-1:0] r;
        logic signed [hslw_pkg::TILE_SW-1:0] s;
        logic                                last;
    } hex_tile_t;

    class hex_walk_scoreboard;
        hex_tile_t expected_tiles[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // four-connected walk, q steps while the error is positive
        function void note_pair(input logic signed [4:0] sq, input logic signed [4:0] sr,
                                input logic signed [4:0] eq, input logic signed [4:0] er);
            int        q0;
            int        r0;
            int        q1;
            int        r1;
            int        dq;
            int        dr;
            int        q_dir;
            int        r_dir;
            int        n_tiles;
            int        err;
            int        cq;
            int        cr;
            int        s_val;
            hex_tile_t t;
            q0 = sq;
            r0 = sr;
            q1 = eq;
            r1 = er;
            dq = (q1 > q0) ? q1 - q0 : q0 - q1;
            dr = (r1 > r0) ? r1 - r0 : r0 - r1;
            q_dir = (q1 > q0) ? 1 : -1;
            r_dir = (r1 > r0) ? 1 : -1;
            n_tiles = 1 + dq + dr;
            err = dq - dr;
            cq = q0;
            cr = r0;
            for (int k = 0; k < n_tiles; k++)
            begin
                s_val  = -cq - cr;
                t.q    = cq[hslw_pkg::TILE_QW-1:0];
                t.r    = cr[hslw_pkg::TILE_QW-1:0];
                t.s    = s_val[hslw_pkg::TILE_SW-1:0];
                t.last = (k == n_tiles - 1);
                expected_tiles.insert(expected_tiles.size(), t);
                if (err > 0)
                begin
                    cq  += q_dir;
                    err -= 2 * dr;
                end
                else
                begin
                    cr  += r_dir;
                    err += 2 * dq;
                end
            end
        endfunction

        function void check_tile(input logic [hslw_pkg::OUT_DATA_W-1:0] data,
                                 input logic last);
            hex_tile_t got;
            hex_tile_t exp_t;
            got.q    = data[4:0];
            got.r    = data[9:5];
            got.s    = data[16:10];
            got.last = last;
            if (expected_tiles.size() == 0)
            begin
                errors++;
                $display("%0t: tile with none expected: q=%0d r=%0d s=%0d last=%0b",
                         $time, got.q, got.r, got.s, got.last);
                return;
            end
            exp_t = expected_tiles.pop_front();
            if (got.q !== exp_t.q)
            begin
                errors++;
                $display("%0t: tile_q expected %0d actual %0d", $time, exp_t.q, got.q);
            end
            if (got.r !== exp_t.r)
            begin
                errors++;
                $display("%0t: tile_r expected %0d actual %0d", $time, exp_t.r, got.r);
            end
            if (got.s !== exp_t.s)
            begin
                errors++;
                $display("%0t: tile_s expected %0d actual %0d", $time, exp_t.s, got.s);
            end
            if (got.last !== exp_t.last)
            begin
                errors++;
                $display("%0t: last_tile expected %0b actual %0b",
                         $time, exp_t.last, got.last);
            end
        endfunction

        function int pending();
            return expected_tiles.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic [hslw_pkg::IN_DATA_W-1:0]    s_tdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [hslw_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                              m_tlast;
    logic                              m_tvalid;
    logic                              m_tready;

    hex_walk_scoreboard line_board;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    bit                 rx_hold_req;
    int                 cycle_count;

    hex_supercover_line_walker #(
        .COORD_BITS (5)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // tile checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            line_board.check_tile(m_tdata, m_tlast);
        end
    end

    // receiver, with one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // entered and left at a falling edge
    task automatic send_pair(input logic [4:0] sq, input logic [4:0] sr,
                             input logic [4:0] eq, input logic [4:0] er);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, er, eq, sr, sq};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        line_board.note_pair(sq, sr, eq, er);
        @(negedge clk);
    endtask

    task automatic send_random_pairs(input int n_items);
        logic [4:0] sq;
        logic [4:0] sr;
        logic [4:0] eq;
        logic [4:0] er;
        for (int i = 0; i < n_items; i++)
        begin
            sq = 5'($urandom_range(0, 31));
            sr = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 99) < 70)
            begin
                eq = 5'($urandom_range(0, 31));
                er = 5'($urandom_range(0, 31));
            end
            else
            begin
                // short lines near the start tile
                eq = sq + 5'($urandom_range(0, 6)) - 5'd3;
                er = sr + 5'($urandom_range(0, 6)) - 5'd3;
            end
            send_pair(sq, sr, eq, er);
        end
    endtask

    initial
    begin
        line_board  = new();
        cycle_count = 0;
        rx_hold_req = 1'b0;
        tx_idle_pct = 22;
        rx_idle_pct = 51;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single tile lines
        send_pair(5'sd0, 5'sd0, 5'sd0, 5'sd0);
        send_pair(-5'sd16, -5'sd16, -5'sd16, -5'sd16);
        send_pair(5'sd15, 5'sd15, 5'sd15, 5'sd15);
        // one axis only
        send_pair(-5'sd16, 5'sd3, 5'sd15, 5'sd3);
        send_pair(5'sd15, -5'sd2, -5'sd16, -5'sd2);
        send_pair(5'sd4, -5'sd16, 5'sd4, 5'sd15);
        send_pair(-5'sd7, 5'sd15, -5'sd7, -5'sd16);
        send_pair(5'sd0, 5'sd0, 5'sd1, 5'sd0);
        send_pair(5'sd0, 5'sd0, 5'sd0, -5'sd1);
        // longest lines, corner to corner
        send_pair(-5'sd16, -5'sd16, 5'sd15, 5'sd15);
        send_pair(5'sd15, 5'sd15, -5'sd16, -5'sd16);
        send_pair(-5'sd16, 5'sd15, 5'sd15, -5'sd16);
        send_pair(5'sd15, -5'sd16, -5'sd16, 5'sd15);
        // equal deltas, ties step r
        send_pair(5'sd0, 5'sd0, 5'sd3, 5'sd3);
        send_pair(5'sd0, 5'sd0, -5'sd5, 5'sd5);
        send_pair(5'sd2, -5'sd1, -5'sd4, -5'sd7);
        send_pair(5'sd0, 5'sd0, 5'sd1, 5'sd1);
        // unequal deltas
        send_pair(5'sd0, 5'sd0, 5'sd7, 5'sd2);
        send_pair(5'sd0, 5'sd0, -5'sd2, 5'sd9);
        send_pair(-5'sd9, 5'sd6, 5'sd11, -5'sd3);

        send_random_pairs(PHASE_ITEMS);

        tx_idle_pct = 51;
        rx_idle_pct = 22;
        send_random_pairs(PHASE_ITEMS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        send_random_pairs(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (line_board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (line_board.errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/hslw_pkg.sv
design/hex_supercover_line_walker.sv
design/hslw_checker.sv
verif/testbench.sv
